// ===== rtl/fir32_pkg.sv =====
`default_nettype none

package fir32_pkg;

    // Filter geometry and datapath widths.
    localparam int TAP_COUNT = 32;
    localparam int ADDR_W    = $clog2(TAP_COUNT);
    localparam int SAMPLE_W  = 16;
    localparam int COEFF_W   = 16;
    localparam int PROD_W    = SAMPLE_W + COEFF_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int RESULT_W  = 17;
    localparam int FRAC_SHIFT = 15;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // Rounding bias added before the arithmetic shift (half an output LSB).
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (FRAC_SHIFT - 1);

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Q1.15 coefficients; the second half mirrors the first.
    localparam logic signed [COEFF_W-1:0] COEFF_ROM [TAP_COUNT] = '{
        -16'sd126,  -16'sd429,   16'sd328,   16'sd1025,
         16'sd527,  -16'sd1275, -16'sd1004,  16'sd224,
         16'sd247,  -16'sd367,   16'sd2086,  16'sd3282,
        -16'sd1705, -16'sd7192, -16'sd2514,  16'sd7171,
         16'sd7171, -16'sd2514, -16'sd7192, -16'sd1705,
         16'sd3282,  16'sd2086, -16'sd367,   16'sd247,
         16'sd224,  -16'sd1004, -16'sd1275,  16'sd527,
         16'sd1025,  16'sd328,  -16'sd429,  -16'sd126
    };

endpackage

`default_nettype wire

// ===== rtl/fir_filter_32tap_shared_mac.sv =====
`default_nettype none

// Channel    Dir   Handshake                      Payload
// s_axis     in    s_axis_tvalid / s_axis_tready  tdata[15:0]  = sample (signed Q1.15)
// m_axis     out   m_axis_tvalid / m_axis_tready  tdata[16:0]  = filtered (signed Q2.15)
//
// Each item is accepted in the idle state, then its 32 taps are read from the tap memory through
// one shared multiply-accumulate; the read, multiply and accumulate registers drain, and the
// rounding state loads the rounded sum into the output register. One item is filtered at a time.
// Reset (rst_n low, asynchronous) clears the control state and the per-tap valid
// bits, so taps that were never written read as zero; no clearing pass is needed.
// A new item is taken while a finished result still waits in the output register;
// a stalled output only holds the next result in the rounding state.

module fir_filter_32tap_shared_mac (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // Fields from bit 0: sample[15:0].
    input  wire logic [fir32_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // Fields from bit 0: filtered[16:0], zeros above.
    output logic [fir32_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);

    import fir32_pkg::*;

    // Tap memory and its per-entry valid bits.
    logic [SAMPLE_W-1:0]  tap_mem [TAP_COUNT];
    logic [TAP_COUNT-1:0] tap_valid_reg;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic [ADDR_W-1:0] rd_addr;

    // Read stage.
    logic                       rd_vld_reg, rd_last_reg, rd_ok_reg;
    logic [SAMPLE_W-1:0]        rd_data_reg;
    logic signed [COEFF_W-1:0]  coef_reg;

    // Multiply stage.
    logic                       mul_vld_reg, mul_last_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SAMPLE_W-1:0] tap_val;

    // Accumulator and output register.
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_rounded;
    logic                       out_vld_reg, out_vld_next;
    logic [RESULT_W-1:0]        out_data_reg;

    logic in_accept;
    logic issue;
    logic load_out;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign rd_addr   = wp_reg - k_reg;
    assign tap_val   = rd_ok_reg ? $signed(rd_data_reg) : '0;
    assign acc_rounded = acc_reg + ROUND_BIAS;

    // Next state and handshake outputs.
    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        issue         = 1'b0;
        load_out      = 1'b0;
        k_next        = k_reg;
        wp_next       = wp_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                k_next        = '0;
                if (s_axis_tvalid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                issue  = 1'b1;
                k_next = k_reg + ADDR_W'(1);
                if (k_reg == ADDR_W'(TAP_COUNT - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (mul_vld_reg && mul_last_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_vld_reg || m_axis_tready)
                begin
                    load_out   = 1'b1;
                    wp_next    = wp_reg + ADDR_W'(1);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
        if (load_out)
        begin
            out_vld_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            k_reg         <= '0;
            tap_valid_reg <= '0;
            rd_vld_reg    <= 1'b0;
            rd_last_reg   <= 1'b0;
            mul_vld_reg   <= 1'b0;
            mul_last_reg  <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            k_reg        <= k_next;
            rd_vld_reg   <= issue;
            rd_last_reg  <= issue && (k_reg == ADDR_W'(TAP_COUNT - 1));
            mul_vld_reg  <= rd_vld_reg;
            mul_last_reg <= rd_last_reg;
            out_vld_reg  <= out_vld_next;
            if (in_accept)
            begin
                tap_valid_reg[wp_reg] <= 1'b1;
            end
        end
    end

    // Tap memory: write the new sample, read one tap per cycle.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            tap_mem[wp_reg] <= s_axis_tdata[SAMPLE_W-1:0];
        end
        rd_data_reg <= tap_mem[rd_addr];
        rd_ok_reg   <= tap_valid_reg[rd_addr];
        coef_reg    <= COEFF_ROM[k_reg];
    end

    // Shared multiplier and accumulator.
    always_ff @(posedge clk)
    begin
        prod_reg <= tap_val * coef_reg;
        if (in_accept)
        begin
            acc_reg <= '0;
        end
        else if (mul_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (load_out)
        begin
            out_data_reg <= acc_rounded[FRAC_SHIFT +: RESULT_W];
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - RESULT_W)'(0), out_data_reg};

endmodule

`default_nettype wire

// ===== rtl/fir32_checker.sv =====
`default_nettype none

module fir32_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                s_axis_tvalid,
    input wire logic                                s_axis_tready,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [fir32_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    import fir32_pkg::*;

    // A pending result stays offered until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item dropped or changed while stalled");

    // The filter works on one item at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item accepted while filtering");

    // A result cannot appear right after its item is taken.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result appeared too early");

    // Padding bits above the result stay zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:RESULT_W] == '0)
        else $error("nonzero padding in output item");

endmodule

bind fir_filter_32tap_shared_mac fir32_checker u_fir32_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
